FILE: rtl/core/tcrm_pkg.sv
// shared types and constants for the track cluster residual matcher
// no dependencies; imported by tcrm_front, tcrm_back and the top level
`default_nettype none

package tcrm_pkg;

  // number of planes that are accepted; a cluster at or above it is dropped
  localparam int unsigned PLANE_COUNT = 64;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned SLOPE_W = 18;
  localparam int unsigned PLANE_W = 6;
  localparam int unsigned RES_W   = 26;
  localparam int unsigned PROD_W  = POS_W + SLOPE_W;
  localparam int unsigned SQ_W    = 2 * RES_W - 1;
  localparam int unsigned DIST_W  = 2 * RES_W;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_REF  = 2'd1;
  localparam logic [1:0] CMD_DUT  = 2'd2;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [SLOPE_W-1:0] slope_x;
    logic signed [SLOPE_W-1:0] slope_y;
    logic [PLANE_W-1:0]        plane;
    logic                      last;
  } item_t;

  // queue handshake between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcrm_front.sv
// front end: accepts input transfers, drops ignored items, queues the rest
// depends on tcrm_pkg
`default_nettype none

module tcrm_front
  import tcrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  in_tlast,
  output q_out_t                     q_out,
  input  wire logic                  q_pop
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  item_t             new_item;
  logic              keep;
  logic              push;
  logic              pop_ok;

  always_comb begin
    new_item.cmd     = in_tuser;
    new_item.pos_x   = in_tdata[23:0];
    new_item.pos_y   = in_tdata[47:24];
    new_item.pos_z   = in_tdata[71:48];
    new_item.slope_x = in_tdata[89:72];
    new_item.slope_y = in_tdata[107:90];
    new_item.plane   = in_tdata[113:108];
    new_item.last    = in_tlast;
  end

  // loads always kept; clusters need a valid command and a plane in range
  always_comb begin
    unique case (in_tuser)
      CMD_LOAD: keep = 1'b1;
      CMD_REF, CMD_DUT:
        keep = ({3'b0, new_item.plane} < 9'(PLANE_COUNT));
      default:  keep = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign pop_ok    = q_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop_ok);
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_out.valid = (cnt_r != '0);
  assign q_out.item  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

FILE: rtl/core/tcrm_back.sv
// back end: track registers, extrapolation, residual, distance search, output register
// depends on tcrm_pkg
`default_nettype none

module tcrm_back
  import tcrm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire q_out_t                 q_out,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RES  = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;

  localparam logic signed [27:0] RES_MAX = 28'sd33554431;
  localparam logic signed [27:0] RES_MIN = -28'sd33554432;
  localparam logic [DIST_W-1:0]  DIST_LIMIT = DIST_W'(1) << (DIST_W - 1);

  logic [2:0]                state_r, state_nxt;
  item_t                     cur_r;
  logic signed [POS_W-1:0]   org_x_r, org_y_r;
  logic signed [SLOPE_W-1:0] slp_x_r, slp_y_r;
  logic                      best_found_r;
  logic [DIST_W-1:0]         best_dist_r;
  logic signed [RES_W-1:0]   best_x_r, best_y_r;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r;
  logic signed [RES_W-1:0]   res_x_r, res_y_r;
  logic [SQ_W-1:0]           sq_x_r, sq_y_r;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;

  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic signed [RES_W-1:0]   res_x, res_y;
  logic signed [DIST_W-1:0]  sqx_full, sqy_full;
  logic [DIST_W-1:0]         sq_sum;
  logic                      take;
  logic                      emit;
  logic                      slot_free;
  logic                      finish;
  logic signed [RES_W-1:0]   sel_x, sel_y;

  // round the Q18.24 product to Q19.8, add origin, subtract cluster, saturate
  function automatic logic signed [RES_W-1:0] resid(
    input logic signed [POS_W-1:0]  org,
    input logic signed [PROD_W-1:0] prod,
    input logic signed [POS_W-1:0]  clu
  );
    logic signed [PROD_W:0] rnd;
    logic signed [27:0]     t;
    rnd = {prod[PROD_W-1], prod} + (PROD_W+1)'(32768);
    t   = {{4{org[POS_W-1]}}, org} + {rnd[PROD_W], rnd[PROD_W:16]}
          - {{4{clu[POS_W-1]}}, clu};
    if (t > RES_MAX) begin
      resid = RES_MAX[RES_W-1:0];
    end else if (t < RES_MIN) begin
      resid = RES_MIN[RES_W-1:0];
    end else begin
      resid = t[RES_W-1:0];
    end
  endfunction

  assign prod_x   = slp_x_r * cur_r.pos_z;
  assign prod_y   = slp_y_r * cur_r.pos_z;
  assign res_x    = resid(org_x_r, prod_x_r, cur_r.pos_x);
  assign res_y    = resid(org_y_r, prod_y_r, cur_r.pos_y);
  assign sqx_full = res_x_r * res_x_r;
  assign sqy_full = res_y_r * res_y_r;
  assign sq_sum   = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign take     = (cur_r.cmd == CMD_DUT) && (!best_found_r || (sq_sum < best_dist_r));

  assign slot_free = !out_valid_r || out_tready;
  assign emit      = (cur_r.cmd == CMD_REF) || cur_r.last;
  assign finish    = (state_r == ST_CMP) && (!emit || slot_free);

  always_comb begin
    if (cur_r.cmd == CMD_REF || take) begin
      sel_x = res_x_r;
      sel_y = res_y_r;
    end else begin
      sel_x = best_x_r;
      sel_y = best_y_r;
    end
  end

  assign q_pop = (state_r == ST_IDLE) && q_out.valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_out.valid && q_out.item.cmd != CMD_LOAD) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_RES;
      ST_RES:  state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      best_found_r <= 1'b0;
      best_dist_r  <= '0;
      best_x_r     <= '0;
      best_y_r     <= '0;
      org_x_r      <= '0;
      org_y_r      <= '0;
      slp_x_r      <= '0;
      slp_y_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && q_out.item.cmd == CMD_LOAD) begin
        org_x_r      <= q_out.item.pos_x;
        org_y_r      <= q_out.item.pos_y;
        slp_x_r      <= q_out.item.slope_x;
        slp_y_r      <= q_out.item.slope_y;
        best_found_r <= 1'b0;
      end
      if (finish) begin
        if (take) begin
          best_dist_r <= sq_sum;
          best_x_r    <= res_x_r;
          best_y_r    <= res_y_r;
        end
        if (cur_r.cmd == CMD_DUT) begin
          best_found_r <= !cur_r.last;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_out.item;
    end
    if (state_r == ST_MUL) begin
      prod_x_r <= prod_x;
      prod_y_r <= prod_y;
    end
    if (state_r == ST_RES) begin
      res_x_r <= res_x;
      res_y_r <= res_y;
    end
    if (state_r == ST_SQR) begin
      sq_x_r <= sqx_full[SQ_W-1:0];
      sq_y_r <= sqy_full[SQ_W-1:0];
    end
    if (finish && emit) begin
      out_data_r <= {6'd0, sel_y, sel_x, cur_r.plane};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_emit_from_cmp : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_CMP)
    else $error("result raised outside the compare step");

  a_load_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_out.item.cmd == CMD_LOAD) |=> !best_found_r && state_r == ST_IDLE)
    else $error("track load did not clear the search");

  a_dist_bound : assert property (@(posedge clk) disable iff (!rst_n)
    best_found_r |-> best_dist_r <= DIST_LIMIT)
    else $error("best distance out of range");

endmodule

`default_nettype wire

FILE: rtl/core/track_cluster_residual_matcher.sv
// top level of the track cluster residual matcher
// depends on tcrm_pkg, tcrm_front and tcrm_back
`default_nettype none

// A track transfer (tuser = load) stores the track origin (Q16.8) and slopes (Q2.16)
// and restarts the search. A reference cluster (tuser = reference) extrapolates
// the track to the cluster z and returns the residual, track minus cluster, at
// once. Test-device clusters (tuser = test) are searched for the smallest
// squared residual, the first one winning a tie; the transfer with tlast set
// returns the best residual of that plane. Residuals saturate to 26 bits.
// Clusters whose plane number is not below PLANE_COUNT, and the unused command
// code, are dropped on input and return nothing. Sequencing: a four-entry queue
// decouples input from processing; the back-end sequencer takes a track load
// in its idle step and steps each cluster through dequeue, multiply, residual,
// square and compare/emit, taking no new item until that cluster is done.
// A cluster that emits waits in the compare step while the output register
// is still held by the sink.

module track_cluster_residual_matcher
  import tcrm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], slope_x[89:72],
  // slope_y[107:90], plane_index[113:108], zero fill[119:114]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  wire logic [1:0]             in_tuser,
  // last_in_plane
  input  wire logic                   in_tlast,
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_plane[5:0], residual_x[31:6], residual_y[57:32], zero fill[63:58]
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  // queue head and pop between front and back
  q_out_t q_out;
  logic   q_pop;

  tcrm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_out     (q_out),
    .q_pop     (q_pop)
  );

  tcrm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_out      (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
